>>> rtl/cop_pkg.sv
// shared types and constants of the circle outline point generator
`timescale 1ns / 1ps

package cop_pkg;

  localparam int CoordW  = 12;
  localparam int PixelW  = 13;
  localparam int RadiusW = 10;
  localparam int OffsetW = 11;
  localparam int StepW   = 12;
  localparam int ErrW    = 14;
  localparam int QuadW   = 3;

  localparam logic [RadiusW:0] MaxRadius = 11'd1023;

  // request kinds
  localparam logic ModeStart = 1'b0;
  localparam logic ModeStep  = 1'b1;

  // quadrant codes
  localparam logic [QuadW-1:0] QuadTopLeft     = 3'd0;
  localparam logic [QuadW-1:0] QuadTopRight    = 3'd1;
  localparam logic [QuadW-1:0] QuadBottomLeft  = 3'd2;
  localparam logic [QuadW-1:0] QuadBottomRight = 3'd3;
  localparam logic [QuadW-1:0] QuadFull        = 3'd4;

  // one iteration waiting to be drawn
  typedef struct packed {
    logic signed [CoordW-1:0]  center_x;
    logic signed [CoordW-1:0]  center_y;
    logic signed [OffsetW-1:0] major;
    logic signed [OffsetW-1:0] minor;
    logic [QuadW-1:0]          quadrant;
    logic                      final_iter;
  } iter_t;

endpackage

>>> rtl/cop_if.sv
// request and point channel interfaces
`timescale 1ns / 1ps

interface cop_req_if;
  import cop_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [CoordW-1:0] center_x;
  logic signed [CoordW-1:0] center_y;
  logic [RadiusW-1:0]       radius;
  logic [QuadW-1:0]         quadrant_select;

  modport source (
    output valid, mode, center_x, center_y, radius, quadrant_select,
    input  ready
  );
  modport sink (
    input  valid, mode, center_x, center_y, radius, quadrant_select,
    output ready
  );
endinterface

interface cop_pt_if;
  import cop_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PixelW-1:0] pixel_x;
  logic signed [PixelW-1:0] pixel_y;
  logic                     last_of_run;
  logic                     finished;

  modport source (
    output valid, pixel_x, pixel_y, last_of_run, finished,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, last_of_run, finished,
    output ready
  );
endinterface

>>> rtl/cop_front.sv
// front end: takes requests, runs the midpoint recurrence, queues iterations
`timescale 1ns / 1ps

module cop_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic                         mode_i,
  input  logic signed [cop_pkg::CoordW-1:0] center_x_i,
  input  logic signed [cop_pkg::CoordW-1:0] center_y_i,
  input  logic [cop_pkg::RadiusW-1:0]  radius_i,
  input  logic [cop_pkg::QuadW-1:0]    quadrant_select_i,
  input  logic                         full_i,
  output logic                         req_ready_o,
  output logic                         push_o,
  output cop_pkg::iter_t               push_data_o
);
  import cop_pkg::*;

  logic signed [OffsetW-1:0] major_q, major_d, minor_q, minor_d;
  logic [StepW-1:0]          step_major_q, step_major_d, step_minor_q, step_minor_d;
  logic signed [ErrW-1:0]    err_q, err_d;
  logic signed [CoordW-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [RadiusW-1:0]        rad_q, rad_d;
  logic [QuadW-1:0]          quad_q, quad_d;
  logic                      busy_q, busy_d;

  // state after an optional start load
  logic signed [OffsetW-1:0] ld_major, ld_minor;
  logic [StepW-1:0]          ld_step_major, ld_step_minor;
  logic signed [ErrW-1:0]    ld_err;
  logic signed [CoordW-1:0]  ld_cx, ld_cy;
  logic [RadiusW-1:0]        ld_rad;
  logic [QuadW-1:0]          ld_quad;
  logic                      ld_busy;

  // advanced state
  logic signed [OffsetW-1:0] nx_major, nx_minor;
  logic [StepW-1:0]          nx_step_major, nx_step_minor;
  logic signed [ErrW-1:0]    nx_err;
  logic                      accept, done;

  assign req_ready_o = !full_i;
  assign accept      = req_valid_i && !full_i;

  always_comb begin
    ld_major      = major_q;
    ld_minor      = minor_q;
    ld_step_major = step_major_q;
    ld_step_minor = step_minor_q;
    ld_err        = err_q;
    ld_cx         = cx_q;
    ld_cy         = cy_q;
    ld_rad        = rad_q;
    ld_quad       = quad_q;
    ld_busy       = busy_q;
    if (mode_i == ModeStart) begin
      ld_rad        = ({1'b0, radius_i} > MaxRadius) ? MaxRadius[RadiusW-1:0] : radius_i;
      ld_cx         = center_x_i;
      ld_cy         = center_y_i;
      ld_quad       = (quadrant_select_i > QuadFull) ? QuadFull : quadrant_select_i;
      ld_major      = $signed({1'b0, ld_rad}) - OffsetW'(1);
      ld_minor      = '0;
      ld_step_major = StepW'(1);
      ld_step_minor = StepW'(1);
      ld_err        = ErrW'(1) - $signed({3'b000, ld_rad, 1'b0});
      ld_busy       = (ld_rad != '0);
    end
  end

  // one midpoint step: two dependent narrow updates
  always_comb begin
    nx_major      = ld_major;
    nx_minor      = ld_minor;
    nx_step_major = ld_step_major;
    nx_step_minor = ld_step_minor;
    nx_err        = ld_err;
    if (nx_err <= 0) begin
      nx_minor      = nx_minor + OffsetW'(1);
      nx_err        = nx_err + $signed({2'b00, nx_step_minor});
      nx_step_minor = nx_step_minor + StepW'(2);
    end
    if (nx_err > 0) begin
      nx_major      = nx_major - OffsetW'(1);
      nx_step_major = nx_step_major + StepW'(2);
      nx_err        = nx_err + $signed({2'b00, nx_step_major})
                      - $signed({3'b000, ld_rad, 1'b0});
    end
    done = (nx_major < nx_minor);
  end

  assign push_o                 = accept && ld_busy;
  assign push_data_o.center_x   = ld_cx;
  assign push_data_o.center_y   = ld_cy;
  assign push_data_o.major      = ld_major;
  assign push_data_o.minor      = ld_minor;
  assign push_data_o.quadrant   = ld_quad;
  assign push_data_o.final_iter = done;

  always_comb begin
    major_d      = major_q;
    minor_d      = minor_q;
    step_major_d = step_major_q;
    step_minor_d = step_minor_q;
    err_d        = err_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    rad_d        = rad_q;
    quad_d       = quad_q;
    busy_d       = busy_q;
    if (accept) begin
      cx_d   = ld_cx;
      cy_d   = ld_cy;
      rad_d  = ld_rad;
      quad_d = ld_quad;
      if (ld_busy) begin
        major_d      = nx_major;
        minor_d      = nx_minor;
        step_major_d = nx_step_major;
        step_minor_d = nx_step_minor;
        err_d        = nx_err;
        busy_d       = !done;
      end else begin
        major_d      = ld_major;
        minor_d      = ld_minor;
        step_major_d = ld_step_major;
        step_minor_d = ld_step_minor;
        err_d        = ld_err;
        busy_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q      <= '0;
      minor_q      <= '0;
      step_major_q <= StepW'(1);
      step_minor_q <= StepW'(1);
      err_q        <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      rad_q        <= '0;
      quad_q       <= QuadFull;
      busy_q       <= 1'b0;
    end else begin
      major_q      <= major_d;
      minor_q      <= minor_d;
      step_major_q <= step_major_d;
      step_minor_q <= step_minor_d;
      err_q        <= err_d;
      cx_q         <= cx_d;
      cy_q         <= cy_d;
      rad_q        <= rad_d;
      quad_q       <= quad_d;
      busy_q       <= busy_d;
    end
  end

endmodule

>>> rtl/cop_queue.sv
// two-entry iteration queue between front and back
`timescale 1ns / 1ps

module cop_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cop_pkg::iter_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output cop_pkg::iter_t head_o
);
  import cop_pkg::*;

  iter_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/cop_back.sv
// back end: expands one iteration into mirrored points, one per cycle unless pt_o stalls
`timescale 1ns / 1ps

module cop_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  cop_pkg::iter_t head_i,
  output logic           pop_o,
  cop_pt_if.source       pt_o
);
  import cop_pkg::*;

  logic [2:0]                idx_q, idx_d;
  logic                      valid_q, valid_d;
  logic signed [PixelW-1:0]  px_q, px_d, py_q, py_d;
  logic                      last_q, last_d, fin_q, fin_d;

  logic                      can_load, swap, neg_x, neg_y, is_last;
  logic [2:0]                last_idx;
  logic signed [OffsetW-1:0] off_x, off_y;
  logic signed [PixelW-1:0]  ox, oy;

  assign can_load = !valid_q || pt_o.ready;
  assign last_idx = (head_i.quadrant == QuadFull) ? 3'd7 : 3'd1;
  assign is_last  = (idx_q == last_idx);
  assign pop_o    = can_load && !empty_i && is_last;

  // mirror pattern of point idx
  always_comb begin
    if (head_i.quadrant == QuadFull) begin
      swap  = idx_q[0] ^ idx_q[1];
      neg_x = idx_q[2] ^ idx_q[1];
      neg_y = idx_q[2];
    end else begin
      swap  = idx_q[0];
      neg_x = !head_i.quadrant[0];
      neg_y = !head_i.quadrant[1];
    end
    off_x = swap ? head_i.minor : head_i.major;
    off_y = swap ? head_i.major : head_i.minor;
    ox    = neg_x ? -PixelW'(off_x) : PixelW'(off_x);
    oy    = neg_y ? -PixelW'(off_y) : PixelW'(off_y);
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    px_d    = px_q;
    py_d    = py_q;
    last_d  = last_q;
    fin_d   = fin_q;
    if (can_load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        px_d   = PixelW'(head_i.center_x) + ox;
        py_d   = PixelW'(head_i.center_y) + oy;
        last_d = is_last;
        fin_d  = is_last && head_i.final_iter;
        idx_d  = is_last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    last_q <= last_d;
    fin_q  <= fin_d;
  end

  assign pt_o.valid       = valid_q;
  assign pt_o.pixel_x     = px_q;
  assign pt_o.pixel_y     = py_q;
  assign pt_o.last_of_run = last_q;
  assign pt_o.finished    = fin_q;

endmodule

>>> rtl/circle_outline_point_generator.sv
// top level of the midpoint circle outline point generator
`timescale 1ns / 1ps

// usage
// - req_i takes requests: mode start loads center, radius and quadrant and
//   draws the first iteration; mode step draws the next iteration
// - point_o gives one outline point per transfer; last_of_run marks the last
//   point of a request, finished the very last point of the circle
// - a full circle request yields eight points, a quadrant request two; a zero
//   radius start or a step with no circle in progress yields none
// - throughput: one point per cycle while point_o is ready and an iteration is
//   queued, set by the single point output register
// - after acceptance, the front registers the iteration into the queue and the
//   back then registers the point
// - front and back are split by a two-entry iteration queue; req_i.ready
//   drops only when the queue is full
// - a stalled point_o holds its point; the back stops and the queue fills
// - reset clears all control state and leaves no circle in progress

module circle_outline_point_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  cop_req_if.sink   req_i,
  cop_pt_if.source  point_o
);
  import cop_pkg::*;

  logic  push, pop, full, empty;
  iter_t push_data, head;

  // front: request intake and recurrence state
  cop_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (req_i.valid),
    .mode_i            (req_i.mode),
    .center_x_i        (req_i.center_x),
    .center_y_i        (req_i.center_y),
    .radius_i          (req_i.radius),
    .quadrant_select_i (req_i.quadrant_select),
    .full_i            (full),
    .req_ready_o       (req_i.ready),
    .push_o            (push),
    .push_data_o       (push_data)
  );

  // iterations waiting to be expanded
  cop_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  // back: point expansion and output register
  cop_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .pt_o    (point_o)
  );

endmodule

>>> bench/circle_outline_point_generator_tb.sv
// self-checking bench for the circle outline point generator, with a built-in point predictor
`timescale 1ns / 1ps

module circle_outline_point_generator_tb;
  import cop_pkg::*;

  // watchdog, far above the slowest legal run
  localparam int unsigned CycleLimit   = 200_000;
  // drawing requests (starts and live steps) in the random phase
  localparam int unsigned RandomDraws  = 190;
  // idling stops for the last stretch of the random phase
  localparam int unsigned QuietFrom    = 155;
  // cycles to keep watching after the last expected point
  localparam int unsigned DrainCycles  = 16;

  // one outline point as seen on point_o
  typedef struct packed {
    logic signed [PixelW-1:0] x;
    logic signed [PixelW-1:0] y;
    logic                     last_of_run;
    logic                     finished;
  } point_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cop_req_if req_if ();
  cop_pt_if  pt_if ();

  circle_outline_point_generator u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .point_o (pt_if)
  );

  always #4 clk_i = ~clk_i;

  // points still owed by the block, oldest first
  point_t      pending_points [$];
  int unsigned mismatch_count = 0;
  int unsigned drawn_requests = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_left     = 0;
  logic        quiet_tail     = 1'b0;

  // rasterizer state mirrored from the block's point of view
  logic signed [OffsetW-1:0] major      = '0;
  logic signed [OffsetW-1:0] minor      = '0;
  logic signed [StepW-1:0]   step_maj   = 1;
  logic signed [StepW-1:0]   step_min   = 1;
  logic signed [ErrW-1:0]    err_acc    = '0;
  logic signed [CoordW-1:0]  held_cx    = '0;
  logic signed [CoordW-1:0]  held_cy    = '0;
  logic signed [RadiusW:0]   held_r     = '0;
  logic [QuadW-1:0]          held_q     = QuadFull;
  logic                      circle_busy = 1'b0;

  // center plus offset, wrapped to the pixel width
  function automatic point_t offset_point(int ox, int oy);
    point_t p;
    p.x           = PixelW'(int'(held_cx) + ox);
    p.y           = PixelW'(int'(held_cy) + oy);
    p.last_of_run = 1'b0;
    p.finished    = 1'b0;
    return p;
  endfunction

  // works out the points one request produces, queues them, returns their count
  function automatic int rasterize_request(logic mode, logic signed [CoordW-1:0] cx,
                                           logic signed [CoordW-1:0] cy,
                                           logic [RadiusW-1:0] rad, logic [QuadW-1:0] qsel);
    point_t run [8];
    int     n;
    int     a;
    int     b;
    n = 0;
    if (mode == ModeStart) begin
      // a start always abandons whatever circle is in flight
      held_cx  = cx;
      held_cy  = cy;
      held_r   = (rad > MaxRadius) ? MaxRadius : {1'b0, rad};
      // unused quadrant codes fall back to the full circle
      held_q   = (qsel > QuadFull) ? QuadFull : qsel;
      major    = OffsetW'(int'(held_r) - 1);
      minor    = '0;
      step_maj = 1;
      step_min = 1;
      err_acc  = ErrW'(1 - 2 * int'(held_r));
      // zero radius leaves major below minor, so nothing gets drawn
      circle_busy = (major >= minor);
    end
    if (!circle_busy) return 0;

    a = int'(major);
    b = int'(minor);
    case (held_q)
      QuadTopLeft: begin
        run[n] = offset_point(-a, -b); n++;
        run[n] = offset_point(-b, -a); n++;
      end
      QuadTopRight: begin
        run[n] = offset_point(a, -b); n++;
        run[n] = offset_point(b, -a); n++;
      end
      QuadBottomLeft: begin
        run[n] = offset_point(-a, b); n++;
        run[n] = offset_point(-b, a); n++;
      end
      QuadBottomRight: begin
        run[n] = offset_point(a, b); n++;
        run[n] = offset_point(b, a); n++;
      end
      default: begin
        // eight octant mirrors, duplicates kept
        run[n] = offset_point(a, b);   n++;
        run[n] = offset_point(b, a);   n++;
        run[n] = offset_point(-b, a);  n++;
        run[n] = offset_point(-a, b);  n++;
        run[n] = offset_point(-a, -b); n++;
        run[n] = offset_point(-b, -a); n++;
        run[n] = offset_point(b, -a);  n++;
        run[n] = offset_point(a, -b);  n++;
      end
    endcase

    // midpoint update: minor moves first, then major if the error went positive
    if (err_acc <= 0) begin
      minor    = minor + 1;
      err_acc  = err_acc + step_min;
      step_min = step_min + 2;
    end
    if (err_acc > 0) begin
      major    = major - 1;
      step_maj = step_maj + 2;
      err_acc  = ErrW'(int'(err_acc) + int'(step_maj) - 2 * int'(held_r));
    end

    run[n-1].last_of_run = 1'b1;
    if (major < minor) begin
      // the iteration just drawn closed the arc
      run[n-1].finished = 1'b1;
      circle_busy       = 1'b0;
    end
    for (int i = 0; i < n; i++) pending_points.push_back(run[i]);
    return n;
  endfunction

  // drives one request and returns once the block has taken it
  task automatic send_request(logic mode, logic signed [CoordW-1:0] cx,
                              logic signed [CoordW-1:0] cy, logic [RadiusW-1:0] rad,
                              logic [QuadW-1:0] qsel);
    int n;
    // random sender gap with valid dropped
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.mode            <= mode;
    req_if.center_x        <= cx;
    req_if.center_y        <= cy;
    req_if.radius          <= rad;
    req_if.quadrant_select <= qsel;
    do @(posedge clk_i); while (!req_if.ready);
    n = rasterize_request(mode, cx, cy, rad, qsel);
    if (mode == ModeStart || n > 0) drawn_requests++;
  endtask

  task automatic start_circle(logic signed [CoordW-1:0] cx, logic signed [CoordW-1:0] cy,
                              logic [RadiusW-1:0] rad, logic [QuadW-1:0] qsel);
    send_request(ModeStart, cx, cy, rad, qsel);
  endtask

  // a step carries junk in the fields the block ignores
  task automatic step_circle();
    send_request(ModeStep, CoordW'($urandom), CoordW'($urandom), RadiusW'($urandom),
                 QuadW'($urandom));
  endtask

  task automatic finish_circle();
    while (circle_busy) step_circle();
  endtask

  // steps before any circle was started are dropped
  task automatic test_idle_steps();
    send_request(ModeStep, '1, '1, '1, '1);
    send_request(ModeStep, '0, '0, '0, '0);
  endtask

  // zero radius start draws nothing, and the following step stays idle
  task automatic test_zero_radius();
    start_circle(12'sd100, -12'sd100, '0, QuadFull);
    step_circle();
  endtask

  // radius one closes in a single iteration; a step after finishing is dropped
  task automatic test_tiny_circles();
    start_circle(12'sd0, 12'sd0, 10'd1, QuadFull);
    step_circle();
  endtask

  // every quadrant code but QuadFull, the unused ones acting as a full circle
  task automatic test_quadrants();
    start_circle(12'sd5, -12'sd7, 10'd2, QuadTopLeft);
    finish_circle();
    start_circle(-12'sd9, 12'sd3, 10'd2, QuadTopRight);
    finish_circle();
    start_circle(12'sd40, 12'sd40, 10'd2, QuadBottomLeft);
    finish_circle();
    start_circle(-12'sd40, -12'sd40, 10'd2, QuadBottomRight);
    finish_circle();
    start_circle(12'sd1, 12'sd1, 10'd1, 3'd5);
    start_circle(12'sd2, 12'sd2, 10'd1, 3'd6);
    start_circle(12'sd3, 12'sd3, 10'd1, 3'd7);
  endtask

  // largest radius at both corner centers, abandoned part way by a restart
  task automatic test_extremes();
    start_circle(-12'sd2048, -12'sd2048, 10'd1023, QuadFull);
    step_circle();
    step_circle();
    start_circle(12'sd2047, 12'sd2047, 10'd1023, QuadFull);
    step_circle();
  endtask

  // mostly whole circles of small radius, some abandoned big ones, some noise
  task automatic test_random_circles();
    int unsigned first;
    int unsigned pick;
    int unsigned steps;
    logic [RadiusW-1:0] rad;
    first = drawn_requests;
    while (drawn_requests - first < RandomDraws) begin
      if (drawn_requests - first >= QuietFrom) quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_request(logic'($urandom), CoordW'($urandom), CoordW'($urandom),
                     RadiusW'($urandom), QuadW'($urandom));
      end else if (pick < 22) begin
        // large circle, left unfinished
        start_circle(CoordW'($urandom), CoordW'($urandom),
                     RadiusW'($urandom_range(49, 1023)), QuadW'($urandom));
        steps = $urandom_range(0, 6);
        repeat (steps) step_circle();
      end else begin
        rad = (pick < 80) ? RadiusW'($urandom_range(1, 12))
                          : RadiusW'($urandom_range(13, 48));
        start_circle(CoordW'($urandom), CoordW'($urandom), rad, QuadW'($urandom));
        if ($urandom_range(0, 6) == 0) begin
          // cut short, the next start restarts mid-circle
          steps = $urandom_range(0, 3);
          repeat (steps) step_circle();
        end else begin
          finish_circle();
          if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) step_circle();
        end
      end
    end
  endtask

  // point sink with random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pt_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      pt_if.ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      pt_if.ready <= 1'b0;
      stall_left  <= $urandom_range(0, 3);
    end else begin
      pt_if.ready <= 1'b1;
    end
  end

  task automatic log_mismatch(string what, point_t want, point_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"mismatch (%s): expected x=%0d y=%0d last=%0b fin=%0b, ",
                "got x=%0d y=%0d last=%0b fin=%0b"},
               what, want.x, want.y, want.last_of_run, want.finished,
               got.x, got.y, got.last_of_run, got.finished);
  endtask

  // point checker, each accepted point against the oldest one owed
  always @(posedge clk_i) begin
    point_t got;
    point_t want;
    if (rst_ni && pt_if.valid && pt_if.ready) begin
      got.x           = pt_if.pixel_x;
      got.y           = pt_if.pixel_y;
      got.last_of_run = pt_if.last_of_run;
      got.finished    = pt_if.finished;
      if (pending_points.size() == 0) begin
        log_mismatch("unexpected point", '0, got);
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.last_of_run !== want.last_of_run ||
            got.finished !== want.finished)
          log_mismatch("wrong point", want, got);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    req_if.valid           <= 1'b0;
    req_if.mode            <= ModeStart;
    req_if.center_x        <= '0;
    req_if.center_y        <= '0;
    req_if.radius          <= '0;
    req_if.quadrant_select <= QuadFull;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_steps();
    test_zero_radius();
    test_tiny_circles();
    test_quadrants();
    test_extremes();
    test_random_circles();

    req_if.valid <= 1'b0;
    // drain, then watch a little longer for stray points
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_points.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> circle_outline_point_generator.f
rtl/cop_pkg.sv
rtl/cop_if.sv
rtl/cop_front.sv
rtl/cop_queue.sv
rtl/cop_back.sv
rtl/circle_outline_point_generator.sv
bench/circle_outline_point_generator_tb.sv
